// ===== rtl/ptc_pkg.sv =====
// Shared types and constants for the pressure/temperature compensation block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package ptc_pkg;

  localparam int DataW = 64;

  localparam logic [1:0] REG_TEMP_CALIB = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
  localparam logic [1:0] REG_PRESS_MID  = 2'd2;
  localparam logic [1:0] REG_PRESS_HIGH = 2'd3;

  localparam logic [DataW-1:0] FINE_OFFSET = 64'd128000;
  localparam logic [DataW-1:0] ADC_FULL    = 64'd1048576;
  localparam logic [DataW-1:0] PRESS_SCALE = 64'd3125;
  localparam logic [DataW-1:0] P1_BIAS     = 64'h0000_8000_0000_0000;
  localparam logic [DataW-1:0] ROUND_HALF  = 64'd128;

  localparam logic signed [DataW-1:0] TEMP_MAX = 64'sd8388607;
  localparam logic signed [DataW-1:0] TEMP_MIN = -64'sd8388608;

  typedef struct packed {
    logic        func;
    logic [19:0] raw_sample;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [23:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               divide_error;
  } out_word_t;

  typedef struct packed {
    logic [47:0] temp_calib;
    logic [47:0] press_calib_low;
    logic [47:0] press_calib_mid;
    logic [47:0] press_calib_high;
  } calib_t;

  // Operation request toward a serial arithmetic unit.
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } op_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] value;
  } op_rsp_t;

  function automatic logic [DataW-1:0] sext16(input logic [15:0] w);
    sext16 = {{(DataW-16){w[15]}}, w};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ptc_mul.sv =====
// Bit-serial 64x64 multiplier, low 64 bits of the product (two's complement wrap).
// One multiplier bit per cycle; depends on ptc_pkg.
`default_nettype none
module ptc_mul (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ptc_pkg::op_req_t req,
  output ptc_pkg::op_rsp_t      rsp
);
  logic [ptc_pkg::DataW-1:0] acc;
  logic [ptc_pkg::DataW-1:0] mcand;
  logic [ptc_pkg::DataW-1:0] mplier;
  logic [5:0]                cnt;
  logic                      busy;
  logic                      done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        acc    <= '0;
        mcand  <= req.a;
        mplier <= req.b;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[ptc_pkg::DataW-2:0], 1'b0};
        mplier <= {1'b0, mplier[ptc_pkg::DataW-1:1]};
        cnt    <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = acc;
endmodule
`default_nettype wire

// ===== rtl/ptc_div.sv =====
// Bit-serial signed 64-bit divider, quotient truncated toward zero.
// Restoring, one quotient bit per cycle; depends on ptc_pkg. Divisor must be nonzero.
`default_nettype none
module ptc_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ptc_pkg::op_req_t req,
  output ptc_pkg::op_rsp_t      rsp
);
  logic [ptc_pkg::DataW-1:0] rem;
  logic [ptc_pkg::DataW-1:0] quo;
  logic [ptc_pkg::DataW-1:0] dvsr;
  logic                      neg;
  logic [5:0]                cnt;
  logic                      busy;
  logic                      done;
  logic [ptc_pkg::DataW:0]   trial;

  assign trial = {rem, quo[ptc_pkg::DataW-1]} - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quo  <= req.a[ptc_pkg::DataW-1] ? -req.a : req.a;
        dvsr <= req.b[ptc_pkg::DataW-1] ? -req.b : req.b;
        neg  <= req.a[ptc_pkg::DataW-1] ^ req.b[ptc_pkg::DataW-1];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[ptc_pkg::DataW]) begin
          rem <= trial[ptc_pkg::DataW-1:0];
        end else begin
          rem <= {rem[ptc_pkg::DataW-2:0], quo[ptc_pkg::DataW-1]};
        end
        quo <= {quo[ptc_pkg::DataW-2:0], ~trial[ptc_pkg::DataW]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = neg ? -quo : quo;
endmodule
`default_nettype wire

// ===== rtl/ptc_seq.sv =====
// Sequencer: walks the compensation polynomials through the serial multiplier
// and divider, holds fine temperature. Depends on ptc_pkg, ptc_mul, ptc_div.
`default_nettype none
module ptc_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ptc_pkg::in_word_t  in_data,
  input  wire ptc_pkg::calib_t    calib,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output ptc_pkg::out_word_t      res
);
  typedef enum logic [1:0] {IDLE, ISSUE, WAIT, FINISH} state_t;
  typedef enum logic [3:0] {
    T_A, T_B, T_C,
    P_V1V1, P_M1P6, P_V1P5, P_M1P3, P_V1P2, P_P1,
    P_N, P_DIV, P_P9Q, P_Q, P_P8
  } step_t;

  state_t state;
  step_t  step;

  logic [19:0]               adc;
  logic [ptc_pkg::DataW-1:0] ra, rb, rc;
  logic [31:0]               fine;

  ptc_pkg::op_req_t mul_req, div_req;
  ptc_pkg::op_rsp_t mul_rsp, div_rsp;

  logic [ptc_pkg::DataW-1:0] opa, opb, prod, q13, tf, tscaled, pfinal, v1_new, psum;
  logic [ptc_pkg::DataW-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [ptc_pkg::DataW-1:0] a_t, b_t, n_p;
  logic [23:0]               tcent;
  logic                      op_done;

  assign t1 = {48'b0, calib.temp_calib[15:0]};
  assign t2 = ptc_pkg::sext16(calib.temp_calib[31:16]);
  assign t3 = ptc_pkg::sext16(calib.temp_calib[47:32]);
  assign p1 = {48'b0, calib.press_calib_low[15:0]};
  assign p2 = ptc_pkg::sext16(calib.press_calib_low[31:16]);
  assign p3 = ptc_pkg::sext16(calib.press_calib_low[47:32]);
  assign p4 = ptc_pkg::sext16(calib.press_calib_mid[15:0]);
  assign p5 = ptc_pkg::sext16(calib.press_calib_mid[31:16]);
  assign p6 = ptc_pkg::sext16(calib.press_calib_mid[47:32]);
  assign p7 = ptc_pkg::sext16(calib.press_calib_high[15:0]);
  assign p8 = ptc_pkg::sext16(calib.press_calib_high[31:16]);
  assign p9 = ptc_pkg::sext16(calib.press_calib_high[47:32]);

  assign a_t  = {47'b0, adc[19:3]} - {47'b0, t1[15:0], 1'b0};
  assign b_t  = {48'b0, adc[19:4]} - t1;
  assign n_p  = ((ptc_pkg::ADC_FULL - {44'b0, adc}) << 31) - rb;
  assign q13  = $signed(rb) >>> 13;
  assign prod = mul_rsp.value;

  // operand select per step
  always_comb begin
    unique case (step)
      T_A:     begin opa = a_t; opb = t2; end
      T_B:     begin opa = b_t; opb = b_t; end
      T_C:     begin opa = rc;  opb = t3; end
      P_V1V1:  begin opa = ra;  opb = ra; end
      P_M1P6:  begin opa = rc;  opb = p6; end
      P_V1P5:  begin opa = ra;  opb = p5; end
      P_M1P3:  begin opa = rc;  opb = p3; end
      P_V1P2:  begin opa = ra;  opb = p2; end
      P_P1:    begin opa = rc;  opb = p1; end
      P_N:     begin opa = n_p; opb = ptc_pkg::PRESS_SCALE; end
      P_DIV:   begin opa = rc;  opb = ra; end
      P_P9Q:   begin opa = p9;  opb = q13; end
      P_Q:     begin opa = rc;  opb = q13; end
      P_P8:    begin opa = p8;  opb = rb; end
      default: begin opa = rc;  opb = ra; end
    endcase
  end

  assign mul_req.start = (state == ISSUE) && (step != P_DIV);
  assign mul_req.a     = opa;
  assign mul_req.b     = opb;
  assign div_req.start = (state == ISSUE) && (step == P_DIV);
  assign div_req.a     = opa;
  assign div_req.b     = opb;
  assign op_done       = (step == P_DIV) ? div_rsp.done : mul_rsp.done;

  // result arithmetic on the finishing steps (shifts are arithmetic)
  assign tf      = ra + {{14{prod[ptc_pkg::DataW-1]}}, prod[ptc_pkg::DataW-1:14]};
  assign tscaled = $signed((tf << 2) + tf + ptc_pkg::ROUND_HALF) >>> 8;
  assign psum    = rb + ra + {{19{prod[ptc_pkg::DataW-1]}}, prod[ptc_pkg::DataW-1:19]};
  assign pfinal  = {{8{psum[ptc_pkg::DataW-1]}}, psum[ptc_pkg::DataW-1:8]} + (p7 << 4);
  assign v1_new  = $signed(prod) >>> 33;

  always_comb begin
    if ($signed(tscaled) > ptc_pkg::TEMP_MAX) begin
      tcent = ptc_pkg::TEMP_MAX[23:0];
    end else if ($signed(tscaled) < ptc_pkg::TEMP_MIN) begin
      tcent = ptc_pkg::TEMP_MIN[23:0];
    end else begin
      tcent = tscaled[23:0];
    end
  end

  ptc_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  ptc_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= T_A;
      fine  <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            adc   <= in_data.raw_sample;
            res   <= ptc_pkg::out_word_t'({in_data.func, 57'b0});
            ra    <= {{32{fine[31]}}, fine} - ptc_pkg::FINE_OFFSET;
            step  <= in_data.func ? P_V1V1 : T_A;
            state <= ISSUE;
          end
        end
        ISSUE: state <= WAIT;
        WAIT: begin
          if (op_done) begin
            state <= ISSUE;
            unique case (step)
              T_A:    begin ra <= $signed(prod) >>> 11; step <= T_B; end
              T_B:    begin rc <= $signed(prod) >>> 12; step <= T_C; end
              T_C: begin
                fine                  <= tf[31:0];
                res.temperature_centi <= tcent;
                state                 <= FINISH;
              end
              P_V1V1: begin rc <= prod; step <= P_M1P6; end
              P_M1P6: begin rb <= prod + (p4 << 35); step <= P_V1P5; end
              P_V1P5: begin rb <= rb + (prod << 17); step <= P_M1P3; end
              P_M1P3: begin rc <= $signed(prod) >>> 8; step <= P_V1P2; end
              P_V1P2: begin rc <= rc + (prod << 12) + ptc_pkg::P1_BIAS; step <= P_P1; end
              P_P1: begin
                ra <= v1_new;
                if (v1_new == '0) begin
                  res.divide_error <= 1'b1;
                  state            <= FINISH;
                end else begin
                  step <= P_N;
                end
              end
              P_N:    begin rc <= prod; step <= P_DIV; end
              P_DIV:  begin rb <= div_rsp.value; step <= P_P9Q; end
              P_P9Q:  begin rc <= prod; step <= P_Q; end
              P_Q:    begin ra <= $signed(prod) >>> 25; step <= P_P8; end
              P_P8: begin
                res.pressure_q24_8 <= pfinal[31:0];
                state              <= FINISH;
              end
              default: state <= IDLE;
            endcase
          end
        end
        FINISH: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign in_ready  = (state == IDLE);
  assign res_valid = (state == FINISH);
endmodule
`default_nettype wire

// ===== rtl/pressure_temperature_compensation.sv =====
// Barometric sensor integer compensation, top level: APB calibration registers,
// sequencer with serial multiplier/divider, output register. Depends on ptc_pkg, ptc_seq.
//
// Usage:
//  - Input channel in_valid/in_ready/in_data carries one word: func (0 temperature,
//    1 pressure) and a 20-bit raw_sample. Output channel out_valid/out_ready/out_data
//    returns exactly one result word per input word, in order.
//  - Calibration: four 48-bit registers on the APB port at byte addresses 0, 8, 16, 24
//    (temp_calib, press_calib_low, press_calib_mid, press_calib_high); 64-bit data,
//    upper 16 bits ignored on write and read as zero. pready is tied high.
//    Write them only while no word is in flight.
//  - Operations: every multiply or divide runs through a bit-serial unit, with an issue
//    state and a writeback around it. A temperature word takes 3 multiplies; a pressure
//    word takes 10 multiplies plus a serial divide, and stops before the divide when the
//    divisor is zero. The serial units set the rate; one word is processed at a time.
//  - A pressure word uses the fine temperature left by the last temperature word.
//  - Reset (rst, synchronous) clears the calibration registers, the fine temperature
//    and all handshake state.
//  - If the receiver stalls, the finished word waits in the output register while the
//    next input word is accepted and computed; that word then holds in the sequencer.
`default_nettype none
module pressure_temperature_compensation (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ptc_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ptc_pkg::out_word_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  ptc_pkg::calib_t    calib;
  ptc_pkg::out_word_t res;
  logic               res_valid;
  logic               res_ready;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      calib <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        ptc_pkg::REG_TEMP_CALIB: calib.temp_calib       <= pwdata[47:0];
        ptc_pkg::REG_PRESS_LOW:  calib.press_calib_low  <= pwdata[47:0];
        ptc_pkg::REG_PRESS_MID:  calib.press_calib_mid  <= pwdata[47:0];
        ptc_pkg::REG_PRESS_HIGH: calib.press_calib_high <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      ptc_pkg::REG_TEMP_CALIB: prdata = {16'b0, calib.temp_calib};
      ptc_pkg::REG_PRESS_LOW:  prdata = {16'b0, calib.press_calib_low};
      ptc_pkg::REG_PRESS_MID:  prdata = {16'b0, calib.press_calib_mid};
      ptc_pkg::REG_PRESS_HIGH: prdata = {16'b0, calib.press_calib_high};
      default:                 prdata = '0;
    endcase
  end

  ptc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .calib    (calib),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register: frees the sequencer while the receiver stalls
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for pressure_temperature_compensation: APB calibration writes,
// directed and random sensor words, a scoreboard that predicts each result word.
// Depends on ptc_pkg and the block's RTL.
`default_nettype none

// Scoreboard: holds a private copy of calibration and fine temperature,
// predicts one result word per accepted sample and checks them in order.
class comp_scoreboard;
  logic [47:0] calib [4];
  logic [31:0] fine_temp;
  ptc_pkg::out_word_t expected_words[$];
  int errors;

  function new();
    foreach (calib[i]) calib[i] = '0;
    fine_temp = '0;
    errors = 0;
  endfunction

  function void set_reg(int idx, logic [63:0] val);
    if (idx >= 0 && idx < 4) calib[idx] = val[47:0];
  endfunction

  static function logic [63:0] asr(logic [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // 16-bit calibration field, sign extended when requested
  function logic [63:0] cword(int r, int idx, bit sgn);
    logic [15:0] w;
    w = calib[r][16*idx +: 16];
    return sgn ? {{48{w[15]}}, w} : {48'd0, w};
  endfunction

  // 64-bit signed divide, truncating toward zero; min / -1 wraps
  static function logic [63:0] sdiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] an, ad, q;
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    q = an / ad;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function ptc_pkg::out_word_t compensate(ptc_pkg::in_word_t w);
    ptc_pkg::out_word_t r;
    logic [63:0] adc, t1, t2, t3, a, b, v1, v2, tf, t;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p, q;
    r = '0;
    r.result_kind = w.func;
    adc = {44'd0, w.raw_sample};
    if (!w.func) begin
      t1 = cword(0, 0, 0);
      t2 = cword(0, 1, 1);
      t3 = cword(0, 2, 1);
      a = (adc >> 3) - (t1 << 1);
      v1 = asr(a * t2, 11);
      b = (adc >> 4) - t1;
      v2 = asr(asr(b * b, 12) * t3, 14);
      tf = v1 + v2;
      fine_temp = tf[31:0];
      t = asr(tf * 64'd5 + 64'd128, 8);
      // clamp to the signed 24-bit range
      if ($signed(t) > 64'sd8388607) t = 64'd8388607;
      else if ($signed(t) < -64'sd8388608) t = -64'sd8388608;
      r.temperature_centi = t[23:0];
    end else begin
      p1 = cword(1, 0, 0); p2 = cword(1, 1, 1); p3 = cword(1, 2, 1);
      p4 = cword(2, 0, 1); p5 = cword(2, 1, 1); p6 = cword(2, 2, 1);
      p7 = cword(3, 0, 1); p8 = cword(3, 1, 1); p9 = cword(3, 2, 1);
      v1 = {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = asr(((64'd1 << 47) + v1) * p1, 33);
      if (v1 == 0) begin
        r.divide_error = 1'b1;
      end else begin
        p = 64'd1048576 - adc;
        p = sdiv64(((p << 31) - v2) * 64'd3125, v1);
        q = asr(p, 13);
        v1 = asr(p9 * q * q, 25);
        v2 = asr(p8 * p, 19);
        p = asr(p + v1 + v2, 8) + (p7 << 4);
        r.pressure_q24_8 = p[31:0];
      end
    end
    return r;
  endfunction

  function void note_sample(ptc_pkg::in_word_t w);
    expected_words.push_back(compensate(w));
  endfunction

  function void check_result(ptc_pkg::out_word_t got);
    ptc_pkg::out_word_t exp_w;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      errors++;
      return;
    end
    exp_w = expected_words.pop_front();
    if (got.result_kind !== exp_w.result_kind ||
        got.temperature_centi !== exp_w.temperature_centi ||
        got.pressure_q24_8 !== exp_w.pressure_q24_8 ||
        got.divide_error !== exp_w.divide_error) begin
      $display("%0t: mismatch expected kind=%0d temp=%0d press=%h err=%0d",
               $time, exp_w.result_kind, $signed(exp_w.temperature_centi),
               exp_w.pressure_q24_8, exp_w.divide_error);
      $display("%0t:          actual   kind=%0d temp=%0d press=%h err=%0d",
               $time, got.result_kind, $signed(got.temperature_centi),
               got.pressure_q24_8, got.divide_error);
      errors++;
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module testbench;
  localparam longint CYCLE_LIMIT = 12_000_000;
  localparam int DRAIN_PAUSE = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ptc_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ptc_pkg::out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  // idle mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both (light)
  int idle_mode = 0;
  int hold_cycles = 0;   // long receiver hold-off, counted down by the receiver
  longint cycles = 0;
  comp_scoreboard sb;

  pressure_temperature_compensation dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: ready changes on the falling edge only.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ready <= ($urandom_range(99) >= 52);
    end else if (idle_mode == 3) begin
      out_ready <= ($urandom_range(99) >= 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result words are checked at the rising edge they are taken.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // APB write: setup then access; the predictor follows at the same point.
  task automatic reg_write(int idx, logic [63:0] val);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 5'(idx * 8); pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Offer one sample word; called at a falling edge, returns at a falling edge.
  task automatic send_sample(bit func, logic [19:0] raw);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 52 : (idle_mode == 3) ? 6 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.func = func;
    in_data.raw_sample = raw;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(in_data);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  // Calibration sets: 0 typical, 1 all zero, 2 all ones, 3 typical jittered,
  // 4 fully random (upper pwdata bits random, must be ignored)
  task automatic load_calib(int kind);
    logic [47:0] typ [4];
    int i;
    typ[0] = {16'hFC18, 16'd26435, 16'd27504};
    typ[1] = {16'd3024, 16'hD643, 16'd36477};
    typ[2] = {16'hFFF9, 16'd140, 16'd2855};
    typ[3] = {16'd6000, 16'hC6F8, 16'd15500};
    for (i = 0; i < 4; i++) begin
      case (kind)
        0: reg_write(i, {16'd0, typ[i]});
        1: reg_write(i, {$urandom(), 32'd0} & 64'hFFFF_0000_0000_0000);
        2: reg_write(i, '1);
        3: reg_write(i, {16'd0, typ[i] ^ 48'({$urandom_range(255), $urandom_range(255),
                                               $urandom_range(255)})});
        default: reg_write(i, {$urandom(), $urandom()});
      endcase
    end
  endtask

  // Mostly a temperature word then a few pressure words; some noise.
  task automatic random_burst(int n);
    int k;
    logic [19:0] raw;
    for (k = 0; k < n; k++) begin
      raw = ($urandom_range(9) == 0) ? 20'($urandom_range(1) ? 20'hFFFFF : 20'h0)
          : ($urandom_range(3) == 0) ? 20'($urandom())
          : 20'(380000 + $urandom_range(200000));
      if (k % 4 == 0 || $urandom_range(9) == 0) send_sample(1'b0, raw);
      else send_sample(1'b1, raw);
    end
  endtask

  initial begin
    int ph;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: typical calibration, field extremes, both operations.
    idle_mode = 0;
    load_calib(0);
    send_sample(1'b1, 20'd415148);  // pressure before any temperature
    send_sample(1'b0, 20'd519888);
    send_sample(1'b1, 20'd415148);
    send_sample(1'b1, 20'h00000);
    send_sample(1'b1, 20'hFFFFF);
    send_sample(1'b0, 20'h00000);
    send_sample(1'b1, 20'd300000);
    send_sample(1'b0, 20'hFFFFF);
    send_sample(1'b1, 20'd500000);
    drain();
    // all-zero calibration: P1 is zero so every pressure divisor is zero
    load_calib(1);
    send_sample(1'b0, 20'hFFFFF);
    send_sample(1'b1, 20'd415148);
    drain();
    // all-ones calibration: extreme signed and unsigned words
    load_calib(2);
    send_sample(1'b0, 20'h00000);
    send_sample(1'b1, 20'h00000);
    send_sample(1'b0, 20'hFFFFF);
    send_sample(1'b1, 20'hFFFFF);
    send_sample(1'b0, 20'hAAAAA);
    send_sample(1'b1, 20'h55555);
    drain();

    // Random phases, rotating idle modes and calibration sets.
    for (ph = 0; ph < 20; ph++) begin
      idle_mode = ph % 4;
      load_calib((ph % 7 == 1) ? 1 : (ph % 7 == 2) ? 2 : (ph % 3 == 0) ? 3
                 : (ph % 3 == 1) ? 4 : 0);
      if (ph == 5) begin
        // long receiver hold-off while the sender keeps offering
        hold_cycles = 6000;
        random_burst(10);
      end
      random_burst(48);
      // sender pauses until every word has come back, then resumes
      in_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clk);
      random_burst(48);
      drain();
    end

    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/ptc_pkg.sv
rtl/ptc_mul.sv
rtl/ptc_div.sv
rtl/ptc_seq.sv
rtl/pressure_temperature_compensation.sv
tb/testbench.sv
